// ===== src/tbgs_pkg.sv =====
`default_nettype none

package tbgs_pkg;

    // Coordinate and edge widths are fixed by the payload fields.
    localparam int COORD_BITS   = 12;
    localparam int EDGE_BITS    = COORD_BITS + 1;
    localparam int AREA_BITS    = 2 * EDGE_BITS;
    localparam int SUM_BITS     = 32;
    localparam int COUNT_BITS   = 32;

    localparam int GROW_BITS    = 9;
    localparam int COV_BITS     = 10;
    localparam int SHRINK_BITS  = 7;
    localparam int DELETE_BITS  = 12;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 12;

    // Shared multiplier: the wide operand is sized for an area, the narrow one for an edge length.
    localparam int MUL_A_BITS   = AREA_BITS;
    localparam int MUL_B_BITS   = EDGE_BITS;
    localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_RECT  = 2'd1;
    localparam logic [1:0] ACT_EMPTY = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_GROW     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COVERAGE = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SHRINK   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DELETE   = 2'd3;

    typedef enum logic [3:0] {
        MUL_AREA,
        MUL_GAP_L,
        MUL_GAP_T,
        MUL_GAP_R,
        MUL_GAP_B,
        MUL_WH,
        MUL_COV,
        MUL_SHR_W,
        MUL_SHR_H
    } mul_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load;
        logic     isect;
        mul_sel_t mul_sel;
        logic     acc_area;
        logic     upd_left;
        logic     upd_top;
        logic     upd_right;
        logic     upd_bottom;
        logic     frame_dims;
        logic     decide;
        logic     shrink_x;
        logic     shrink_y;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic hit;
        logic out_busy;
    } dp_status_t;

    typedef struct packed {
        logic [1:0]            action;
        logic [COORD_BITS-1:0] rect_x;
        logic [COORD_BITS-1:0] rect_y;
        logic [COORD_BITS-1:0] rect_width;
        logic [COORD_BITS-1:0] rect_height;
        logic                  last_rect;
    } rect_t;

    typedef struct packed {
        logic                  delete_box;
        logic [EDGE_BITS-1:0]  box_left;
        logic [EDGE_BITS-1:0]  box_top;
        logic [EDGE_BITS-1:0]  box_right;
        logic [EDGE_BITS-1:0]  box_bottom;
        logic [COUNT_BITS-1:0] alive_frames;
    } box_t;

endpackage

`default_nettype wire

// ===== src/tbgs_ctrl.sv =====
`default_nettype none

module tbgs_ctrl
    import tbgs_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rect_valid,
    input  wire logic [1:0] rect_action,
    output logic            rect_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_ISECT = 15'b000000000000010,
        S_MAREA = 15'b000000000000100,
        S_GL    = 15'b000000000001000,
        S_GT    = 15'b000000000010000,
        S_GR    = 15'b000000000100000,
        S_GB    = 15'b000000001000000,
        S_GDONE = 15'b000000010000000,
        S_FDIM  = 15'b000000100000000,
        S_FAREA = 15'b000001000000000,
        S_FCOV  = 15'b000010000000000,
        S_FTEST = 15'b000100000000000,
        S_FSX   = 15'b001000000000000,
        S_FSY   = 15'b010000000000000,
        S_EMIT  = 15'b100000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = MUL_AREA;
        rect_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                rect_stall = 1'b0;
                if (rect_valid)
                begin
                    cmd.accept = 1'b1;
                    case (rect_action)
                        ACT_LOAD:  cmd.load   = 1'b1;
                        ACT_RECT:  state_next = S_ISECT;
                        ACT_EMPTY: state_next = S_FDIM;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_ISECT:
            begin
                cmd.isect  = 1'b1;
                state_next = S_MAREA;
            end
            S_MAREA:
            begin
                cmd.mul_sel = MUL_AREA;
                if (status.hit)
                begin
                    state_next = S_GL;
                end
                else if (status.last)
                begin
                    state_next = S_FDIM;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_GL:
            begin
                cmd.mul_sel  = MUL_GAP_L;
                cmd.acc_area = 1'b1;
                state_next   = S_GT;
            end
            S_GT:
            begin
                cmd.mul_sel  = MUL_GAP_T;
                cmd.upd_left = 1'b1;
                state_next   = S_GR;
            end
            S_GR:
            begin
                cmd.mul_sel = MUL_GAP_R;
                cmd.upd_top = 1'b1;
                state_next  = S_GB;
            end
            S_GB:
            begin
                cmd.mul_sel   = MUL_GAP_B;
                cmd.upd_right = 1'b1;
                state_next    = S_GDONE;
            end
            S_GDONE:
            begin
                cmd.upd_bottom = 1'b1;
                state_next     = status.last ? S_FDIM : S_IDLE;
            end
            S_FDIM:
            begin
                cmd.frame_dims = 1'b1;
                state_next     = S_FAREA;
            end
            S_FAREA:
            begin
                cmd.mul_sel = MUL_WH;
                state_next  = S_FCOV;
            end
            S_FCOV:
            begin
                cmd.mul_sel = MUL_COV;
                state_next  = S_FTEST;
            end
            S_FTEST:
            begin
                cmd.decide  = 1'b1;
                cmd.mul_sel = MUL_SHR_W;
                state_next  = S_FSX;
            end
            S_FSX:
            begin
                cmd.mul_sel  = MUL_SHR_H;
                cmd.shrink_x = 1'b1;
                state_next   = S_FSY;
            end
            S_FSY:
            begin
                cmd.shrink_y = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                // Wait here until the output register is free for the next transfer.
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/tbgs_datapath.sv =====
`default_nettype none

module tbgs_datapath
    import tbgs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rect_t                     rect_data,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire dp_cmd_t                   cmd,
    output dp_status_t                     status,
    output logic                           box_valid,
    input  wire logic                      box_stall,
    output box_t                           box_data
);

    localparam int GROW_PROD_BITS = EDGE_BITS + GROW_BITS;
    localparam int GSTEP_BITS     = GROW_PROD_BITS - 7;
    localparam int SHR_PROD_BITS  = EDGE_BITS + SHRINK_BITS;
    localparam int SSTEP_BITS     = SHR_PROD_BITS - 7;
    localparam int CMP_BITS       = SUM_BITS + 8;
    localparam logic [EDGE_BITS-1:0]  EDGE_MAX  = {EDGE_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Left or top edge moving outward: the step is rounded up, the edge floors at zero.
    function automatic logic [EDGE_BITS-1:0] grow_low(input logic [EDGE_BITS-1:0] e,
                                                      input logic [GROW_PROD_BITS-1:0] p);
        logic [GROW_PROD_BITS:0] rounded;
        logic [GSTEP_BITS-1:0]   step;
        rounded = {1'b0, p} + (GROW_PROD_BITS + 1)'(255);
        step    = rounded[GROW_PROD_BITS:8];
        if (step > GSTEP_BITS'(e))
        begin
            return '0;
        end
        return e - step[EDGE_BITS-1:0];
    endfunction

    function automatic logic [EDGE_BITS-1:0] grow_high(input logic [EDGE_BITS-1:0] e,
                                                       input logic [GROW_PROD_BITS-1:0] p);
        logic [GSTEP_BITS-1:0] sum;
        sum = GSTEP_BITS'(e) + GSTEP_BITS'(p[GROW_PROD_BITS-1:8]);
        if (sum > GSTEP_BITS'(EDGE_MAX))
        begin
            return EDGE_MAX;
        end
        return sum[EDGE_BITS-1:0];
    endfunction

    function automatic logic [EDGE_BITS-1:0] shrink_low(input logic [EDGE_BITS-1:0] e,
                                                        input logic [SHR_PROD_BITS-1:0] p);
        logic [EDGE_BITS:0] sum;
        sum = {1'b0, e} + (EDGE_BITS + 1)'(p[SHR_PROD_BITS-1:8]);
        if (sum > {1'b0, EDGE_MAX})
        begin
            return EDGE_MAX;
        end
        return sum[EDGE_BITS-1:0];
    endfunction

    function automatic logic [EDGE_BITS-1:0] shrink_high(input logic [EDGE_BITS-1:0] e,
                                                         input logic [SHR_PROD_BITS-1:0] p);
        logic [SHR_PROD_BITS:0] rounded;
        logic [SSTEP_BITS-1:0]  step;
        rounded = {1'b0, p} + (SHR_PROD_BITS + 1)'(255);
        step    = rounded[SHR_PROD_BITS:8];
        if (step > SSTEP_BITS'(e))
        begin
            return '0;
        end
        return e - step[EDGE_BITS-1:0];
    endfunction

    // Configuration
    logic [GROW_BITS-1:0]   grow_reg;
    logic [COV_BITS-1:0]    cov_reg;
    logic [SHRINK_BITS-1:0] shrink_reg;
    logic [DELETE_BITS-1:0] delsize_reg;

    // Box state
    logic [EDGE_BITS-1:0]  left_reg,   left_next;
    logic [EDGE_BITS-1:0]  top_reg,    top_next;
    logic [EDGE_BITS-1:0]  right_reg,  right_next;
    logic [EDGE_BITS-1:0]  bottom_reg, bottom_next;
    logic [SUM_BITS-1:0]   sum_reg,    sum_next;
    logic                  any_reg,    any_next;
    logic [COUNT_BITS-1:0] count_reg,  count_next;

    // Captured rectangle and per-rectangle work values
    logic [EDGE_BITS-1:0]  rl_reg, rt_reg, rr_reg, rb_reg;
    logic                  last_reg;
    logic [EDGE_BITS-1:0]  dx_reg, dy_reg;
    logic                  hit_reg;
    logic [EDGE_BITS-1:0]  gap_l_reg, gap_t_reg, gap_r_reg, gap_b_reg;
    logic                  grow_l_reg, grow_t_reg, grow_r_reg, grow_b_reg;
    logic [EDGE_BITS-1:0]  w_reg, h_reg;
    logic                  del_reg, shr_reg;
    logic [PROD_BITS-1:0]  product_reg;

    logic                  box_valid_reg, box_valid_next;
    box_t                  box_reg;

    logic [EDGE_BITS-1:0]  in_left, in_top, in_right, in_bottom;
    logic [EDGE_BITS-1:0]  ix0, ix1, iy0, iy1;
    logic [MUL_A_BITS-1:0] mul_a;
    logic [MUL_B_BITS-1:0] mul_b;
    logic [PROD_BITS-1:0]  product;
    logic [SUM_BITS:0]     sum_wide;
    logic                  cov_low;
    logic                  need_fix;
    logic                  too_small;

    assign in_left   = EDGE_BITS'(rect_data.rect_x);
    assign in_top    = EDGE_BITS'(rect_data.rect_y);
    assign in_right  = EDGE_BITS'(rect_data.rect_x) + EDGE_BITS'(rect_data.rect_width);
    assign in_bottom = EDGE_BITS'(rect_data.rect_y) + EDGE_BITS'(rect_data.rect_height);

    assign ix0 = (rl_reg > left_reg)   ? rl_reg : left_reg;
    assign ix1 = (rr_reg < right_reg)  ? rr_reg : right_reg;
    assign iy0 = (rt_reg > top_reg)    ? rt_reg : top_reg;
    assign iy1 = (rb_reg < bottom_reg) ? rb_reg : bottom_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_AREA:
            begin
                mul_a = MUL_A_BITS'(dx_reg);
                mul_b = dy_reg;
            end
            MUL_GAP_L:
            begin
                mul_a = MUL_A_BITS'(gap_l_reg);
                mul_b = MUL_B_BITS'(grow_reg);
            end
            MUL_GAP_T:
            begin
                mul_a = MUL_A_BITS'(gap_t_reg);
                mul_b = MUL_B_BITS'(grow_reg);
            end
            MUL_GAP_R:
            begin
                mul_a = MUL_A_BITS'(gap_r_reg);
                mul_b = MUL_B_BITS'(grow_reg);
            end
            MUL_GAP_B:
            begin
                mul_a = MUL_A_BITS'(gap_b_reg);
                mul_b = MUL_B_BITS'(grow_reg);
            end
            MUL_WH:
            begin
                mul_a = MUL_A_BITS'(w_reg);
                mul_b = h_reg;
            end
            MUL_COV:
            begin
                // The previous product holds the box area.
                mul_a = product_reg[AREA_BITS-1:0];
                mul_b = MUL_B_BITS'(cov_reg);
            end
            MUL_SHR_W:
            begin
                mul_a = MUL_A_BITS'(w_reg);
                mul_b = MUL_B_BITS'(shrink_reg);
            end
            MUL_SHR_H:
            begin
                mul_a = MUL_A_BITS'(h_reg);
                mul_b = MUL_B_BITS'(shrink_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product  = mul_a * mul_b;
    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS + 1)'(product_reg[AREA_BITS-1:0]);

    // Coverage is compared by cross multiplication; a zero area never tests low.
    assign cov_low   = CMP_BITS'({sum_reg, 8'b0}) < CMP_BITS'(product_reg);
    assign need_fix  = !any_reg || cov_low;
    assign too_small = (w_reg < EDGE_BITS'(delsize_reg)) || (h_reg < EDGE_BITS'(delsize_reg));

    always_comb
    begin
        left_next   = left_reg;
        top_next    = top_reg;
        right_next  = right_reg;
        bottom_next = bottom_reg;
        sum_next    = sum_reg;
        any_next    = any_reg;
        count_next  = count_reg;
        if (cmd.load)
        begin
            left_next   = in_left;
            top_next    = in_top;
            right_next  = in_right;
            bottom_next = in_bottom;
            sum_next    = '0;
            any_next    = 1'b0;
            count_next  = COUNT_BITS'(1);
        end
        if (cmd.acc_area)
        begin
            sum_next = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
            any_next = 1'b1;
        end
        if (cmd.upd_left && grow_l_reg)
        begin
            left_next = grow_low(left_reg, product_reg[GROW_PROD_BITS-1:0]);
        end
        if (cmd.upd_top && grow_t_reg)
        begin
            top_next = grow_low(top_reg, product_reg[GROW_PROD_BITS-1:0]);
        end
        if (cmd.upd_right && grow_r_reg)
        begin
            right_next = grow_high(right_reg, product_reg[GROW_PROD_BITS-1:0]);
        end
        if (cmd.upd_bottom && grow_b_reg)
        begin
            bottom_next = grow_high(bottom_reg, product_reg[GROW_PROD_BITS-1:0]);
        end
        if (cmd.frame_dims && (count_reg != COUNT_MAX))
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        if (cmd.shrink_x && shr_reg)
        begin
            left_next  = shrink_low(left_reg, product_reg[SHR_PROD_BITS-1:0]);
            right_next = shrink_high(right_reg, product_reg[SHR_PROD_BITS-1:0]);
        end
        if (cmd.shrink_y && shr_reg)
        begin
            top_next    = shrink_low(top_reg, product_reg[SHR_PROD_BITS-1:0]);
            bottom_next = shrink_high(bottom_reg, product_reg[SHR_PROD_BITS-1:0]);
        end
        if (cmd.emit)
        begin
            sum_next = '0;
            any_next = 1'b0;
        end
    end

    always_comb
    begin
        box_valid_next = box_valid_reg;
        if (cmd.emit)
        begin
            box_valid_next = 1'b1;
        end
        else if (!box_stall)
        begin
            box_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grow_reg      <= GROW_BITS'(128);
            cov_reg       <= COV_BITS'(128);
            shrink_reg    <= SHRINK_BITS'(13);
            delsize_reg   <= DELETE_BITS'(10);
            left_reg      <= '0;
            top_reg       <= '0;
            right_reg     <= '0;
            bottom_reg    <= '0;
            sum_reg       <= '0;
            any_reg       <= 1'b0;
            count_reg     <= COUNT_BITS'(1);
            box_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GROW:     grow_reg    <= cfg_data[GROW_BITS-1:0];
                    CFG_COVERAGE: cov_reg     <= cfg_data[COV_BITS-1:0];
                    CFG_SHRINK:   shrink_reg  <= cfg_data[SHRINK_BITS-1:0];
                    CFG_DELETE:   delsize_reg <= cfg_data[DELETE_BITS-1:0];
                    default:      grow_reg    <= grow_reg;
                endcase
            end
            left_reg      <= left_next;
            top_reg       <= top_next;
            right_reg     <= right_next;
            bottom_reg    <= bottom_next;
            sum_reg       <= sum_next;
            any_reg       <= any_next;
            count_reg     <= count_next;
            box_valid_reg <= box_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= product;
        if (cmd.accept)
        begin
            rl_reg   <= in_left;
            rt_reg   <= in_top;
            rr_reg   <= in_right;
            rb_reg   <= in_bottom;
            last_reg <= rect_data.last_rect;
        end
        if (cmd.isect)
        begin
            dx_reg     <= ix1 - ix0;
            dy_reg     <= iy1 - iy0;
            hit_reg    <= (ix1 > ix0) && (iy1 > iy0);
            gap_l_reg  <= left_reg - rl_reg;
            gap_t_reg  <= top_reg - rt_reg;
            gap_r_reg  <= rr_reg - right_reg;
            gap_b_reg  <= rb_reg - bottom_reg;
            grow_l_reg <= rl_reg < left_reg;
            grow_t_reg <= rt_reg < top_reg;
            grow_r_reg <= rr_reg > right_reg;
            grow_b_reg <= rb_reg > bottom_reg;
        end
        if (cmd.frame_dims)
        begin
            w_reg <= (right_reg >= left_reg) ? right_reg - left_reg : '0;
            h_reg <= (bottom_reg >= top_reg) ? bottom_reg - top_reg : '0;
        end
        if (cmd.decide)
        begin
            del_reg <= need_fix && too_small;
            shr_reg <= need_fix && !too_small;
        end
        if (cmd.emit)
        begin
            box_reg.delete_box   <= del_reg;
            box_reg.box_left     <= left_reg;
            box_reg.box_top      <= top_reg;
            box_reg.box_right    <= right_reg;
            box_reg.box_bottom   <= bottom_reg;
            box_reg.alive_frames <= count_reg;
        end
    end

    assign status.last     = last_reg;
    assign status.hit      = hit_reg;
    assign status.out_busy = box_valid_reg && box_stall;
    assign box_valid       = box_valid_reg;
    assign box_data        = box_reg;

endmodule

`default_nettype wire

// ===== src/tracking_box_grow_shrink.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// rect      in         rect_valid/rect_stall   rect_t: action, rectangle, last_rect
// box       out        box_valid/box_stall     box_t: delete flag, edges, alive_frames
// cfg       in         cfg_write               cfg_index, cfg_data
//
// A load completes in the idle state. A rectangle runs an intersect and an area step and,
// when it overlaps, a step per edge, as the single shared multiplier does each product in turn.
// Ending a frame (last rectangle or empty frame) adds area, coverage and shrink products.
// No clearing pass: box state, config and output valid reset with rst_n, work registers do not.
// The result waits in an output register; a stalled box channel holds the block only
// when the next frame result is ready and the previous one was not yet transferred.
module tracking_box_grow_shrink
    import tbgs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rect_valid,
    output logic                           rect_stall,
    input  wire rect_t                     rect_data,
    input  wire logic                      cfg_write,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    output logic                           box_valid,
    input  wire logic                      box_stall,
    output box_t                           box_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    tbgs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .rect_valid  (rect_valid),
        .rect_action (rect_data.action),
        .rect_stall  (rect_stall),
        .status      (status),
        .cmd         (cmd)
    );

    tbgs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .rect_data (rect_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .box_valid (box_valid),
        .box_stall (box_stall),
        .box_data  (box_data)
    );

    // A new result appears only from the emit step of the sequencer.
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(box_valid) |-> $past(cmd.emit))
        else $error("box_valid rose without an emit step");

    // Emit is issued only when the output register is free, so it always lands.
    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> box_valid)
        else $error("emitted result did not reach the output register");

    // The sequencer issues at most one datapath step per cycle.
    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.isect, cmd.acc_area, cmd.upd_left, cmd.upd_top,
                  cmd.upd_right, cmd.upd_bottom, cmd.frame_dims, cmd.decide,
                  cmd.shrink_x, cmd.shrink_y, cmd.emit}))
        else $error("more than one datapath step in a cycle");

endmodule

`default_nettype wire
